// ===== design/base64url_stream_encoder_top_defines.svh =====
// Assertion macros shared by the base64url stream encoder.
`ifndef BASE64URL_STREAM_ENCODER_TOP_DEFINES_SVH
`define BASE64URL_STREAM_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define B64U_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("base64url encoder: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define B64U_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("base64url encoder: next-cycle check failed");

`endif

// ===== design/b64u_pkg.sv =====
// Package: types, constants and the sextet-to-ASCII mapping of the encoder.
package b64u_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [5:0] sextet_t;
  typedef logic [6:0] ascii_t;

  // Position inside a group of three bytes.
  typedef enum logic [2:0] {
    PH0 = 3'b001,
    PH1 = 3'b010,
    PH2 = 3'b100
  } phase_t;

  // One queued character beat.
  typedef struct packed {
    ascii_t code_char;
    logic   final_char;
  } char_beat_t;

  // What one byte produces: one or two beats.
  typedef struct packed {
    logic       two;
    char_beat_t c0;
    char_beat_t c1;
  } enc_t;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam ascii_t ASCII_DASH       = 7'h2D;
  localparam ascii_t ASCII_UNDERSCORE = 7'h5F;

  function automatic ascii_t sextet_to_ascii(input sextet_t v);
    ascii_t c;
    case (v) inside
      [6'd0:6'd25]:  c = 7'(v) + 7'd65;
      [6'd26:6'd51]: c = 7'(v) + 7'd71;
      [6'd52:6'd61]: c = {1'b0, v - 6'd4};
      6'd62:         c = ASCII_DASH;
      default:       c = ASCII_UNDERSCORE;
    endcase
    return c;
  endfunction

endpackage

// ===== design/b64u_byte_if.sv =====
// Interface: raw byte channel with last-of-message mark.
interface b64u_byte_if;
  logic              valid;
  logic              ready;
  b64u_pkg::byte_t   data_byte;
  logic              end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

// ===== design/b64u_char_if.sv =====
// Interface: encoded character channel with final-character mark.
interface b64u_char_if;
  logic              valid;
  logic              ready;
  b64u_pkg::ascii_t  code_char;
  logic              final_char;

  modport source (output valid, output code_char, output final_char, input ready);
  modport sink   (input valid, input code_char, input final_char, output ready);
endinterface

// ===== design/b64u_enc_core.sv =====
// Module: group-phase tracker and sextet builder for one byte.
module b64u_enc_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  b64u_pkg::byte_t  data_byte,
  input  logic             end_of_message,
  output b64u_pkg::enc_t   enc
);
  import b64u_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  resid_r, resid_nxt;
  sextet_t     s0, s1;
  logic        two;
  phase_t      ph_after;
  logic [3:0]  res_after;

  always_comb begin
    s1        = data_byte[5:0];
    two       = 1'b0;
    case (phase_r)
      PH1: begin
        s0        = {resid_r[1:0], data_byte[7:4]};
        res_after = data_byte[3:0];
        ph_after  = PH2;
      end
      PH2: begin
        s0        = {resid_r[3:0], data_byte[7:6]};
        two       = 1'b1;
        res_after = 4'd0;
        ph_after  = PH0;
      end
      default: begin
        s0        = data_byte[7:2];
        res_after = {2'b00, data_byte[1:0]};
        ph_after  = PH1;
      end
    endcase

    // Flush leftover bits, zero-filled on the right.
    if (end_of_message && !two) begin
      two = 1'b1;
      s1  = (ph_after == PH1) ? {res_after[1:0], 4'd0} : {res_after[3:0], 2'd0};
    end

    phase_nxt = end_of_message ? PH0  : ph_after;
    resid_nxt = end_of_message ? 4'd0 : res_after;

    enc.two           = two;
    enc.c0.code_char  = sextet_to_ascii(s0);
    enc.c0.final_char = 1'b0;
    enc.c1.code_char  = sextet_to_ascii(s1);
    enc.c1.final_char = end_of_message;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH0;
      resid_r <= 4'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      resid_r <= resid_nxt;
    end
  end

endmodule

// ===== design/base64url_stream_encoder_top.sv =====
// Top level: base64url (URL-safe, unpadded) byte-to-character stream encoder.
//
// Input channel in_bus carries one raw byte per beat plus end_of_message,
// which marks the last byte of a message. Output channel out_bus carries one
// ASCII character per beat; final_char is set on the last character of a
// message. Both channels use valid/ready; a beat moves when both are high.
// Each byte yields one or two characters: the first two bytes of a group of
// three yield one, the third yields two, and the last byte of a message
// always yields two (its leftover bits are flushed as a zero-filled char).
// Latency: with the queue empty, a byte's first character is offered the
// cycle after the byte is taken. Throughput: one character per ready cycle on
// the output; the output port is the limit. A four-entry character queue sits
// between the encoder and the output, so bytes keep arriving while earlier
// characters wait; in_bus.ready drops only when fewer than two queue slots
// would be free. A receiver stall fills the queue and then holds bytes back;
// nothing is lost. Synchronous reset (rst_n low) empties the queue and
// returns the group phase to the start of a message.
module base64url_stream_encoder_top (
  input  logic   clk,
  input  logic   rst_n,
  b64u_byte_if.sink   in_bus,
  b64u_char_if.source out_bus
);
  import b64u_pkg::*;
  `include "base64url_stream_encoder_top_defines.svh"

  enc_t                 enc;
  logic                 push, pop;
  logic [QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic [QCNT_W-1:0]    base;
  char_beat_t           q_r   [QDEPTH];
  char_beat_t           q_nxt [QDEPTH];

  // Take a byte only when two slots are guaranteed free.
  assign in_bus.ready = (cnt_r < QCNT_W'(QDEPTH - 1));
  assign push         = in_bus.valid && in_bus.ready;

  assign out_bus.valid      = (cnt_r != '0);
  assign out_bus.code_char  = q_r[0].code_char;
  assign out_bus.final_char = q_r[0].final_char;
  assign pop                = out_bus.valid && out_bus.ready;

  b64u_enc_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (push),
    .data_byte      (in_bus.data_byte),
    .end_of_message (in_bus.end_of_message),
    .enc            (enc)
  );

  // Shift-out queue: head at entry 0; advance on pop, append after survivors.
  always_comb begin
    base = cnt_r - QCNT_W'(pop);
    for (int i = 0; i < QDEPTH - 1; i++) begin
      q_nxt[i] = pop ? q_r[i+1] : q_r[i];
    end
    q_nxt[QDEPTH-1] = q_r[QDEPTH-1];
    for (int i = 0; i < QDEPTH; i++) begin
      if (push && (QCNT_W'(i) == base)) begin
        q_nxt[i] = enc.c0;
      end
      if (push && enc.two && (QCNT_W'(i) == base + QCNT_W'(1))) begin
        q_nxt[i] = enc.c1;
      end
    end
    cnt_nxt = base + (push ? (enc.two ? QCNT_W'(2) : QCNT_W'(1)) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  // Queue never overruns.
  `B64U_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= QCNT_W'(QDEPTH))
  // Last byte of a message always lands two characters.
  `B64U_ASSERT_NXT(a_eom_two, push && in_bus.end_of_message, cnt_r >= QCNT_W'(2))
  // Input backpressure only while characters are pending.
  `B64U_ASSERT_IMP(a_stall_pending, !in_bus.ready, out_bus.valid)

endmodule

// ===== sim/b64u_encoding_checker.sv =====
// Checker: predicts base64url characters from accepted bytes and compares them.
module b64u_encoding_checker
  import b64u_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  b64u_byte_if  byte_ch,
  b64u_char_if  char_ch,
  output int    mismatch_count,
  output int    chars_pending
);

  localparam int unsigned REPORT_LIMIT = 10;

  // URL-safe alphabet, first character in the top byte.
  localparam logic [8*64-1:0] URL_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

  char_beat_t expected_chars[$];
  phase_t     grp_phase;
  logic [3:0] leftover_bits;

  function automatic ascii_t sextet_char(input sextet_t v);
    int pos;
    pos = 8 * (63 - int'(v));
    return URL_ALPHABET[pos +: 7];
  endfunction

  // Advance the group state by one byte and queue the characters it yields.
  task automatic encode_byte(input byte_t b, input logic eom);
    sextet_t    sx[2];
    int         n;
    char_beat_t beat;
    n = 0;
    case (grp_phase)
      PH1: begin
        sx[0] = {leftover_bits[1:0], b[7:4]};
        n = 1;
        leftover_bits = b[3:0];
        grp_phase = PH2;
      end
      PH2: begin
        sx[0] = {leftover_bits, b[7:6]};
        sx[1] = b[5:0];
        n = 2;
        leftover_bits = '0;
        grp_phase = PH0;
      end
      default: begin
        sx[0] = b[7:2];
        n = 1;
        leftover_bits = {2'b00, b[1:0]};
        grp_phase = PH1;
      end
    endcase
    if (eom) begin
      // Flush leftover bits, zero-filled on the right.
      if (grp_phase == PH1 && n < 2) begin
        sx[n] = {leftover_bits[1:0], 4'b0000};
        n++;
      end else if (grp_phase == PH2 && n < 2) begin
        sx[n] = {leftover_bits, 2'b00};
        n++;
      end
      leftover_bits = '0;
      grp_phase = PH0;
    end
    for (int k = 0; k < n; k++) begin
      beat.code_char  = sextet_char(sx[k]);
      beat.final_char = eom && (k == n - 1);
      expected_chars.push_back(beat);
    end
  endtask

  initial begin
    mismatch_count = 0;
    chars_pending  = 0;
    grp_phase      = PH0;
    leftover_bits  = '0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      grp_phase     = PH0;
      leftover_bits = '0;
      expected_chars.delete();
    end else begin
      if (char_ch.valid && char_ch.ready) begin
        if (expected_chars.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("unexpected char beat: code 0x%02h final %0b",
                     char_ch.code_char, char_ch.final_char);
        end else begin
          if (char_ch.code_char !== expected_chars[0].code_char ||
              char_ch.final_char !== expected_chars[0].final_char) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("char mismatch: expected code 0x%02h final %0b, got code 0x%02h final %0b",
                       expected_chars[0].code_char, expected_chars[0].final_char,
                       char_ch.code_char, char_ch.final_char);
          end
          void'(expected_chars.pop_front());
        end
      end
      if (byte_ch.valid && byte_ch.ready)
        encode_byte(byte_ch.data_byte, byte_ch.end_of_message);
    end
    chars_pending = expected_chars.size();
  end

endmodule

// ===== sim/base64url_stream_encoder_top_tb.sv =====
// Testbench top: drives byte messages into the encoder and gives the verdict.
module base64url_stream_encoder_top_tb;
  import b64u_pkg::*;

  // Long receiver hold-off: well beyond the four-entry character queue, so the
  // encoder must stall its byte input while the sender keeps offering.
  localparam int unsigned HOLD_OFF_CYCLES = 60;
  localparam int unsigned DRAIN_CYCLES    = 10;
  localparam int unsigned DIRECTED_COUNT  = 19;

  logic clk = 1'b0;
  logic rst_n;

  int   src_idle_pct;
  int   sink_idle_pct;
  logic hold_off_req;
  int   mismatch_count;
  int   chars_pending;

  // Directed messages: one, two, three, four and five bytes long, so the last
  // byte lands in every group phase; extremes of the byte and both special
  // alphabet characters appear.
  byte_t dir_bytes[DIRECTED_COUNT] = '{
    8'h00,
    8'hFF,
    8'hFF, 8'h00,
    8'hFB, 8'hFF, 8'hBF,
    8'h00, 8'h00, 8'h00,
    8'h12, 8'h34, 8'h56, 8'h78,
    8'hAA, 8'h55, 8'hFF, 8'h00, 8'h80
  };
  logic dir_last[DIRECTED_COUNT] = '{
    1'b1,
    1'b1,
    1'b0, 1'b1,
    1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b1
  };

  b64u_byte_if byte_ch ();
  b64u_char_if char_ch ();

  base64url_stream_encoder_top u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (byte_ch),
    .out_bus (char_ch)
  );

  b64u_encoding_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .byte_ch        (byte_ch),
    .char_ch        (char_ch),
    .mismatch_count (mismatch_count),
    .chars_pending  (chars_pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Offer one byte beat. Called at a falling edge; returns at the falling edge
  // after the beat was taken, with valid still high so that the next call can
  // keep it up without lowering it in the same step.
  task automatic push_byte(input byte_t b, input logic eom);
    while ($urandom_range(99) < src_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(negedge clk);
    end
    byte_ch.valid          <= 1'b1;
    byte_ch.data_byte      <= b;
    byte_ch.end_of_message <= eom;
    do @(posedge clk); while (!byte_ch.ready);
    @(negedge clk);
  endtask

  // Send whole messages with random content until about `target` bytes went in.
  // Most messages are short; some run over several groups.
  task automatic send_messages(input int target);
    int    sent;
    int    len;
    byte_t b;
    sent = 0;
    while (sent < target) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
      for (int k = 0; k < len; k++) begin
        // Lean on the byte extremes and the two URL-safe characters now and then.
        if ($urandom_range(5) == 0) begin
          case ($urandom_range(3))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            2:       b = 8'hFB;
            default: b = 8'hBF;
          endcase
        end else begin
          b = byte_t'($urandom_range(255));
        end
        push_byte(b, k == len - 1);
      end
      sent += len;
    end
  endtask

  // Drop valid and hold the sender until every predicted character has left.
  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    do @(negedge clk); while (chars_pending != 0);
  endtask

  // Receiver: random ready per cycle, or a long hold-off when one is requested.
  initial begin
    char_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        char_ch.ready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        char_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else begin
        char_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    rst_n                  = 1'b0;
    byte_ch.valid          = 1'b0;
    byte_ch.data_byte      = '0;
    byte_ch.end_of_message = 1'b0;
    hold_off_req           = 1'b0;
    src_idle_pct           = 17;
    sink_idle_pct          = 45;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed messages first, under the first idling mix.
    for (int i = 0; i < DIRECTED_COUNT; i++)
      push_byte(dir_bytes[i], dir_last[i]);

    // Sender idles lightly, receiver heavily.
    send_messages(175);

    // Pause the sender until every expected character has come out.
    wait_drained();

    // Swap the idling mix: sender idles heavily, receiver lightly.
    src_idle_pct  = 45;
    sink_idle_pct = 17;
    send_messages(175);
    wait_drained();

    // No idling; start with a long receiver hold-off while bytes keep coming,
    // so the character queue fills and the byte input backs up.
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_off_req  = 1'b1;
    send_messages(180);

    // Wait out the remaining characters, then allow a drain period for strays.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
